// ----- design/met_pkg.sv -----
// Shared widths, codes, command/status types and helpers for the escape-time core.
package met_pkg;

  localparam int COORD_BITS     = 40;
  localparam int STEP_BITS      = 39;
  localparam int HALF_BITS      = COORD_BITS / 2;
  localparam int PROD_BITS      = COORD_BITS + HALF_BITS;
  localparam int EXACT_BITS     = 2 * COORD_BITS;
  localparam int WIDE_BITS      = EXACT_BITS + 4;
  localparam int MAG_BITS       = 47;
  localparam int CFG_DATA_BITS  = 40;
  localparam int CFG_INDEX_BITS = 3;

  localparam int FRACTION_BITS_DEFAULT  = 28;
  localparam int ITERATION_BITS_DEFAULT = 24;
  localparam int PIXEL_BITS_DEFAULT     = 14;

  // bailout radius 20, compared squared
  localparam int BAILOUT_SQ_INT = 400;

  localparam logic signed [COORD_BITS-1:0] LEFT_EDGE_RESET = -40'sd671088640;
  localparam logic signed [COORD_BITS-1:0] TOP_EDGE_RESET  = 40'sd295279001;
  localparam logic [STEP_BITS-1:0]         STEP_RESET      = 39'd983040;
  localparam int                           ITER_LIMIT_RESET = 200;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LEFT_EDGE       = 3'd0,
    REG_TOP_EDGE        = 3'd1,
    REG_COLUMN_STEP     = 3'd2,
    REG_ROW_STEP        = 3'd3,
    REG_ITERATION_LIMIT = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    MUL_NONE  = 4'd0,
    MUL_COL   = 4'd1,
    MUL_ROW   = 4'd2,
    MUL_XX_LO = 4'd3,
    MUL_XX_HI = 4'd4,
    MUL_YY_LO = 4'd5,
    MUL_YY_HI = 4'd6,
    MUL_XY_LO = 4'd7,
    MUL_XY_HI = 4'd8
  } mul_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    acc_load;
    logic    wr_xsq;
    logic    wr_ysq;
    logic    wr_xy;
    logic    form_cross;
    logic    ld_x0;
    logic    ld_y0;      // also clears z and the count
    logic    ld_mag;
    logic    update;
    logic    res_load;
    logic    res_inside;
  } dp_cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic escape;
  } dp_status_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [WIDE_BITS-1:0] v
  );
    logic signed [WIDE_BITS-1:0] hi_lim;
    logic signed [WIDE_BITS-1:0] lo_lim;
    hi_lim = {{(WIDE_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    lo_lim = {{(WIDE_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
    if (v > hi_lim) begin
      return {1'b0, {(COORD_BITS-1){1'b1}}};
    end else if (v < lo_lim) begin
      return {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      return v[COORD_BITS-1:0];
    end
  endfunction

endpackage

// ----- design/met_datapath.sv -----
// Datapath: shared 40x20 multiplier, square/cross accumulation, z update, count, result regs.
module met_datapath #(
  parameter int FRACTION_BITS  = met_pkg::FRACTION_BITS_DEFAULT,
  parameter int ITERATION_BITS = met_pkg::ITERATION_BITS_DEFAULT,
  parameter int PIXEL_BITS     = met_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     accept,
  input  logic [PIXEL_BITS-1:0]                    column,
  input  logic [PIXEL_BITS-1:0]                    row,
  input  logic signed [met_pkg::COORD_BITS-1:0]    left_edge,
  input  logic signed [met_pkg::COORD_BITS-1:0]    top_edge,
  input  logic [met_pkg::STEP_BITS-1:0]            column_step,
  input  logic [met_pkg::STEP_BITS-1:0]            row_step,
  input  logic [ITERATION_BITS-1:0]                iteration_limit,
  input  met_pkg::dp_cmd_t                         cmd,
  output met_pkg::dp_status_t                      status,
  output logic [ITERATION_BITS-1:0]                iteration_count,
  output logic                                     inside_set,
  output logic [met_pkg::MAG_BITS-1:0]             escape_magnitude_squared
);

  localparam int CB         = met_pkg::COORD_BITS;
  localparam int HB         = met_pkg::HALF_BITS;
  localparam int PB         = met_pkg::PROD_BITS;
  localparam int EB         = met_pkg::EXACT_BITS;
  localparam int WB         = met_pkg::WIDE_BITS;
  localparam int MB         = met_pkg::MAG_BITS;
  localparam int SQ_BITS    = EB - FRACTION_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;
  localparam int CMP_BITS   = (SUM_BITS > FRACTION_BITS + 10) ? SUM_BITS : FRACTION_BITS + 10;
  localparam int SAT_BITS   = (SUM_BITS > MB + 1) ? SUM_BITS : MB + 1;
  localparam int Q_BITS     = EB - FRACTION_BITS + 1;
  localparam int CROSS_BITS = Q_BITS + 1;
  localparam logic [CMP_BITS-1:0] BAILOUT =
    CMP_BITS'(met_pkg::BAILOUT_SQ_INT) << FRACTION_BITS;

  logic [PIXEL_BITS-1:0]        col_q;
  logic [PIXEL_BITS-1:0]        row_q;
  logic [CB-1:0]                mx;
  logic [CB-1:0]                my;
  logic [CB-1:0]                mul_a;
  logic [HB-1:0]                mul_b;
  logic [PB-1:0]                p;
  logic [PB-1:0]                acc;
  logic [EB-1:0]                exact;
  logic [SQ_BITS-1:0]           xsq;
  logic [SQ_BITS-1:0]           ysq;
  logic [EB-1:0]                xy;
  logic [SUM_BITS-1:0]          sum;
  logic [SAT_BITS-1:0]          sum_w;
  logic [MB-1:0]                mag_sat;
  logic signed [SUM_BITS-1:0]   diff;
  logic [Q_BITS-1:0]            q;
  logic                         rest;
  logic                         neg;
  logic [CROSS_BITS-1:0]        q_ext;
  logic signed [CROSS_BITS-1:0] cross_term;
  logic signed [CB-1:0]         x;
  logic signed [CB-1:0]         y;
  logic signed [CB-1:0]         x0;
  logic signed [CB-1:0]         y0;
  logic signed [WB-1:0]         x0_sum;
  logic signed [WB-1:0]         y0_sum;
  logic signed [WB-1:0]         x_sum;
  logic signed [WB-1:0]         y_sum;
  logic [ITERATION_BITS-1:0]    iter;

  // operand select for the shared multiplier
  always_comb begin
    unique case (cmd.mul_op)
      met_pkg::MUL_COL: begin
        mul_a = CB'(column_step);
        mul_b = HB'(col_q);
      end
      met_pkg::MUL_ROW: begin
        mul_a = CB'(row_step);
        mul_b = HB'(row_q);
      end
      met_pkg::MUL_XX_LO: begin
        mul_a = mx;
        mul_b = mx[HB-1:0];
      end
      met_pkg::MUL_XX_HI: begin
        mul_a = mx;
        mul_b = mx[CB-1:HB];
      end
      met_pkg::MUL_YY_LO: begin
        mul_a = my;
        mul_b = my[HB-1:0];
      end
      met_pkg::MUL_YY_HI: begin
        mul_a = my;
        mul_b = my[CB-1:HB];
      end
      met_pkg::MUL_XY_LO: begin
        mul_a = mx;
        mul_b = my[HB-1:0];
      end
      met_pkg::MUL_XY_HI: begin
        mul_a = mx;
        mul_b = my[CB-1:HB];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign exact = EB'(acc) + {p, {HB{1'b0}}};

  assign sum     = SUM_BITS'(xsq) + SUM_BITS'(ysq);
  assign sum_w   = SAT_BITS'(sum);
  assign mag_sat = (|sum_w[SAT_BITS-1:MB]) ? {MB{1'b1}} : sum_w[MB-1:0];

  // floor(2xy / 2^F) from the exact |x||y|
  assign q     = xy[EB-1:FRACTION_BITS-1];
  assign rest  = |xy[FRACTION_BITS-2:0];
  assign neg   = x[CB-1] ^ y[CB-1];
  assign q_ext = CROSS_BITS'(q);

  assign x0_sum = WB'(left_edge) + $signed(WB'(p));
  assign y0_sum = WB'(top_edge) - $signed(WB'(p));
  assign x_sum  = WB'(diff) + WB'(x0);
  assign y_sum  = WB'(cross_term) + WB'(y0);

  assign status.limit_hit = (iter >= iteration_limit);
  assign status.escape    = (CMP_BITS'(sum) >= BAILOUT);

  always_ff @(posedge clk) begin
    if (accept) begin
      col_q <= column;
      row_q <= row;
    end
    if (cmd.mul_op != met_pkg::MUL_NONE) begin
      p <= PB'(mul_a) * PB'(mul_b);
    end
    if (cmd.acc_load) begin
      acc <= p;
    end
    if (cmd.wr_xsq) begin
      xsq <= exact[EB-1:FRACTION_BITS];
    end
    if (cmd.wr_ysq) begin
      ysq <= exact[EB-1:FRACTION_BITS];
    end
    if (cmd.wr_xy) begin
      xy   <= exact;
      diff <= $signed(SUM_BITS'(xsq)) - $signed(SUM_BITS'(ysq));
    end
    if (cmd.form_cross) begin
      cross_term <= neg ? $signed(~q_ext + CROSS_BITS'(!rest)) : $signed(q_ext);
    end
    if (cmd.ld_x0) begin
      x0 <= met_pkg::sat_coord(x0_sum);
    end
    if (cmd.ld_y0) begin
      y0   <= met_pkg::sat_coord(y0_sum);
      x    <= '0;
      y    <= '0;
      iter <= '0;
    end else if (cmd.update) begin
      x    <= met_pkg::sat_coord(x_sum);
      y    <= met_pkg::sat_coord(y_sum);
      iter <= iter + 1'b1;
    end
    if (cmd.ld_mag) begin
      mx <= x[CB-1] ? CB'(-x) : CB'(x);
      my <= y[CB-1] ? CB'(-y) : CB'(y);
    end
    if (cmd.res_load) begin
      iteration_count          <= iter;
      inside_set               <= cmd.res_inside;
      escape_magnitude_squared <= cmd.res_inside ? '0 : mag_sat;
    end
  end

endmodule

// ----- design/met_ctrl.sv -----
// Controller: sequences mapping, multiply halves, escape/limit checks and the result beat.
module met_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  met_pkg::dp_status_t status,
  output met_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);

  typedef enum logic [13:0] {
    ST_IDLE     = 14'h0001,
    ST_MAP_COL  = 14'h0002,
    ST_MAP_ROW  = 14'h0004,
    ST_MAP_DONE = 14'h0008,
    ST_CHECK    = 14'h0010,
    ST_XX_LO    = 14'h0020,
    ST_XX_HI    = 14'h0040,
    ST_YY_LO    = 14'h0080,
    ST_YY_HI    = 14'h0100,
    ST_XY_LO    = 14'h0200,
    ST_XY_HI    = 14'h0400,
    ST_XY_ACC   = 14'h0800,
    ST_CROSS    = 14'h1000,
    ST_UPDATE   = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_op = met_pkg::MUL_NONE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_MAP_COL;
        end
      end
      ST_MAP_COL: begin
        cmd.mul_op = met_pkg::MUL_COL;
        state_next = ST_MAP_ROW;
      end
      ST_MAP_ROW: begin
        cmd.mul_op = met_pkg::MUL_ROW;
        cmd.ld_x0  = 1'b1;
        state_next = ST_MAP_DONE;
      end
      ST_MAP_DONE: begin
        cmd.ld_y0  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.ld_mag = 1'b1;
        if (status.limit_hit) begin
          cmd.res_load   = 1'b1;
          cmd.res_inside = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          state_next = ST_XX_LO;
        end
      end
      ST_XX_LO: begin
        cmd.mul_op = met_pkg::MUL_XX_LO;
        state_next = ST_XX_HI;
      end
      ST_XX_HI: begin
        cmd.mul_op   = met_pkg::MUL_XX_HI;
        cmd.acc_load = 1'b1;
        state_next   = ST_YY_LO;
      end
      ST_YY_LO: begin
        cmd.wr_xsq = 1'b1;
        cmd.mul_op = met_pkg::MUL_YY_LO;
        state_next = ST_YY_HI;
      end
      ST_YY_HI: begin
        cmd.mul_op   = met_pkg::MUL_YY_HI;
        cmd.acc_load = 1'b1;
        state_next   = ST_XY_LO;
      end
      ST_XY_LO: begin
        cmd.wr_ysq = 1'b1;
        cmd.mul_op = met_pkg::MUL_XY_LO;
        state_next = ST_XY_HI;
      end
      ST_XY_HI: begin
        // both squares are settled here
        if (status.escape) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          cmd.mul_op   = met_pkg::MUL_XY_HI;
          cmd.acc_load = 1'b1;
          state_next   = ST_XY_ACC;
        end
      end
      ST_XY_ACC: begin
        cmd.wr_xy  = 1'b1;
        state_next = ST_CROSS;
      end
      ST_CROSS: begin
        cmd.form_cross = 1'b1;
        state_next     = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_CHECK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.res_load;
    end
  end

  assign busy = (state != ST_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat did not make the core busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_CHECK || $past(state) == ST_XY_HI))
    else $error("result beat not preceded by a limit or escape decision");

endmodule

// ----- design/mandelbrot_escape_time_core.sv -----
// Top level: configuration registers, controller and datapath of the escape-time core.
//
//   channel   ports                                          handshake
//   --------  ---------------------------------------------  -------------------------------
//   pixel     column, row                                    start & !busy at the clock edge
//   result    iteration_count, inside_set,                   done, one cycle, no back-pressure
//             escape_magnitude_squared
//   config    cfg_index, cfg_data                            cfg_write, taken at the edge
//
// Iteration: one shared 40x20 multiplier forms each exact square and the product x*y in
// two halves before z = z*z + c is updated. done pulses in the first idle cycle after a
// pixel is finished, and a new start is taken in that cycle.
// Reset: rst (synchronous) returns to idle and loads the default view and limit registers.
// Config writes are expected only while idle. The result beat cannot be stalled.
module mandelbrot_escape_time_core #(
  parameter int FRACTION_BITS  = met_pkg::FRACTION_BITS_DEFAULT,
  parameter int ITERATION_BITS = met_pkg::ITERATION_BITS_DEFAULT,
  parameter int PIXEL_BITS     = met_pkg::PIXEL_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [PIXEL_BITS-1:0]                column,
  input  logic [PIXEL_BITS-1:0]                row,
  input  logic                                 cfg_write,
  input  logic [met_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [met_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                 done,
  output logic [ITERATION_BITS-1:0]            iteration_count,
  output logic                                 inside_set,
  output logic [met_pkg::MAG_BITS-1:0]         escape_magnitude_squared
);

  logic signed [met_pkg::COORD_BITS-1:0] left_edge;
  logic signed [met_pkg::COORD_BITS-1:0] top_edge;
  logic [met_pkg::STEP_BITS-1:0]         column_step;
  logic [met_pkg::STEP_BITS-1:0]         row_step;
  logic [ITERATION_BITS-1:0]             iteration_limit;
  logic                                  accept;
  met_pkg::dp_cmd_t                      cmd;
  met_pkg::dp_status_t                   status;

  assign accept = start & ~busy;

  // view and limit registers; indexes outside the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      left_edge       <= met_pkg::LEFT_EDGE_RESET;
      top_edge        <= met_pkg::TOP_EDGE_RESET;
      column_step     <= met_pkg::STEP_RESET;
      row_step        <= met_pkg::STEP_RESET;
      iteration_limit <= ITERATION_BITS'(met_pkg::ITER_LIMIT_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        met_pkg::REG_LEFT_EDGE: begin
          left_edge <= $signed(cfg_data[met_pkg::COORD_BITS-1:0]);
        end
        met_pkg::REG_TOP_EDGE: begin
          top_edge <= $signed(cfg_data[met_pkg::COORD_BITS-1:0]);
        end
        met_pkg::REG_COLUMN_STEP: begin
          column_step <= cfg_data[met_pkg::STEP_BITS-1:0];
        end
        met_pkg::REG_ROW_STEP: begin
          row_step <= cfg_data[met_pkg::STEP_BITS-1:0];
        end
        met_pkg::REG_ITERATION_LIMIT: begin
          iteration_limit <= cfg_data[ITERATION_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  met_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  met_datapath #(
    .FRACTION_BITS  (FRACTION_BITS),
    .ITERATION_BITS (ITERATION_BITS),
    .PIXEL_BITS     (PIXEL_BITS)
  ) u_datapath (
    .clk                      (clk),
    .accept                   (accept),
    .column                   (column),
    .row                      (row),
    .left_edge                (left_edge),
    .top_edge                 (top_edge),
    .column_step              (column_step),
    .row_step                 (row_step),
    .iteration_limit          (iteration_limit),
    .cmd                      (cmd),
    .status                   (status),
    .iteration_count          (iteration_count),
    .inside_set               (inside_set),
    .escape_magnitude_squared (escape_magnitude_squared)
  );

  a_inside_zero_mag: assert property (@(posedge clk) disable iff (rst)
    (done && inside_set) |-> (escape_magnitude_squared == '0))
    else $error("inside point reported a nonzero magnitude");

  a_inside_count: assert property (@(posedge clk) disable iff (rst)
    (done && inside_set) |-> (iteration_count == iteration_limit))
    else $error("inside point count differs from the limit");

endmodule
